### rtl/psoe_pkg.sv
// Shared constants, field widths, command codes and the xorshift step for the shuffle-order engine.
package psoe_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;

	localparam int RNG_W  = 32;
	localparam int MODE_W = 3;
	localparam int POS_W  = 8;
	localparam int SEED_W = 32;
	localparam int ITEM_W = 6;
	localparam int CPOS_W = 7;
	localparam int QLEN_W = 7;
	localparam int APB_W  = 32;
	localparam int ADDR_W = 3;

	localparam int XS_A = 13;
	localparam int XS_B = 17;
	localparam int XS_C = 5;

	localparam logic [RNG_W-1:0] RNG_RESET = 32'h9E37_79B9;
	localparam logic [RNG_W-1:0] SEED_MUL  = 32'd2654435761;

	localparam logic [MODE_W-1:0] MODE_RESTART = 3'd0;
	localparam logic [MODE_W-1:0] MODE_START   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_NEXT    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PREV    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SHUFFLE = 3'd4;
	localparam logic [MODE_W-1:0] MODE_ENDED   = 3'd5;
	localparam logic [MODE_W-1:0] MODE_STOP    = 3'd6;

	// Register index decoded from the word address.
	localparam logic [ADDR_W-3:0] REG_QLEN = 1'b0;

	function automatic logic [RNG_W-1:0] xorshift32(input logic [RNG_W-1:0] s);
		logic [RNG_W-1:0] t;
		t = s ^ (s << XS_A);
		t = t ^ (t >> XS_B);
		t = t ^ (t << XS_C);
		return t;
	endfunction

endpackage

### rtl/psoe_cmd_if.sv
// Command channel: one word per playlist command.
interface psoe_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [psoe_pkg::MODE_W-1:0]       mode;
	logic signed [psoe_pkg::POS_W-1:0] position;
	logic                              shuffle_request;
	logic [psoe_pkg::SEED_W-1:0]       time_seed;

	modport source (output valid, output mode, output position, output shuffle_request,
		output time_seed, input ready);
	modport sink (input valid, input mode, input position, input shuffle_request,
		input time_seed, output ready);
endinterface

### rtl/psoe_rsp_if.sv
// Result channel: one status word per command.
interface psoe_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [psoe_pkg::ITEM_W-1:0]        item_index;
	logic signed [psoe_pkg::CPOS_W-1:0] current_pos;
	logic                               has_track;
	logic                               shuffle_state;
	logic                               queue_running;
	logic                               start_failed;

	modport source (output valid, output item_index, output current_pos, output has_track,
		output shuffle_state, output queue_running, output start_failed, input ready);
	modport sink (input valid, input item_index, input current_pos, input has_track,
		input shuffle_state, input queue_running, input start_failed, output ready);
endinterface

### rtl/psoe_rem.sv
// Bit-serial remainder unit: 32-bit dividend modulo a small divisor, one bit per cycle.
module psoe_rem #(
	parameter int QUEUE_DEPTH = psoe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [psoe_pkg::RNG_W-1:0]   dividend,
	input  logic [$clog2(QUEUE_DEPTH):0] divisor,
	output logic                         done,
	output logic [$clog2(QUEUE_DEPTH)-1:0] rem
);

	localparam int IW    = $clog2(QUEUE_DEPTH);
	localparam int DW    = IW + 1;
	localparam int CNT_W = $clog2(psoe_pkg::RNG_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(psoe_pkg::RNG_W - 1);

	logic                       busy_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [psoe_pkg::RNG_W-1:0] num_q;
	logic [DW-1:0]              den_q;
	logic [DW-1:0]              r_q;
	logic [DW:0]                trial;

	// Shift in the next dividend bit and subtract when the divisor fits.
	assign trial = {r_q, num_q[psoe_pkg::RNG_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			r_q   <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (trial >= {1'b0, den_q}) begin
				r_q <= DW'(trial - {1'b0, den_q});
			end else begin
				r_q <= DW'(trial);
			end
		end
	end

	assign done = done_q;
	assign rem  = r_q[IW-1:0];

endmodule

### rtl/playlist_shuffle_order_engine_core.sv
// Top level of the playlist shuffle-order engine: play-order memory, command sequencer, APB register.
//
// Commands arrive as words on the cmd channel (valid/ready) and each one produces exactly one
// status word on the rsp channel. The queue length is set through the APB port (register 0 at
// byte address 0) and should only be written while no command is in flight.
//
// The block handles one command at a time. cmd.ready is high only while the sequencer is idle.
// Restart, start, next, prev, track-end and stop are short commands. Turning shuffle on is the
// long command: each Fisher-Yates swap waits for the bit-serial remainder unit and then reads
// and writes the play-order memory, and a queue of n entries takes n - 1 such swaps.
// Turning shuffle off is a short command.
//
// The result sits in an output register. If the receiver stalls, the block still accepts and
// works on the next command and only waits when it has a second result to hand over.
//
// Reset clears the position to "no track", both flags, and loads the generator seed. The play
// order memory is not swept: a per-entry valid bit makes every unwritten entry read as its own
// address, which is the identity order. Restart and shuffle re-establish identity by clearing
// those valid bits, for the first n entries, all at once.
module playlist_shuffle_order_engine_core #(
	parameter int QUEUE_DEPTH = psoe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	psoe_cmd_if.sink                      cmd,
	psoe_rsp_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [psoe_pkg::ADDR_W-1:0]   paddr,
	input  logic [psoe_pkg::APB_W-1:0]    pwdata,
	output logic [psoe_pkg::APB_W-1:0]    prdata,
	output logic                          pready
);

	// Entry index width, signed position width, length width, and a width wide enough
	// to step a position or take the raw request without overflow.
	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = IW + 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);
	localparam int TW = ((CW > psoe_pkg::POS_W) ? CW : psoe_pkg::POS_W) + 1;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISP,
		S_GT_RD,
		S_GT_CHK,
		S_SH_RDJ,
		S_SH_START,
		S_SH_RNG,
		S_SH_DIV,
		S_SW_RDI,
		S_SW_RDK,
		S_SW_WRI,
		S_SW_WRK,
		S_SRCH,
		S_FX_RD,
		S_FX_WRP,
		S_FX_WRC,
		S_RDCUR,
		S_OUT
	} state_t;

	state_t state_q;

	// Configuration register.
	logic [psoe_pkg::QLEN_W-1:0] qlen_q;
	logic                        cfg_wr;
	logic [psoe_pkg::ADDR_W-3:0] cfg_idx;

	// Latched command.
	logic [psoe_pkg::MODE_W-1:0]       mode_q;
	logic signed [psoe_pkg::POS_W-1:0] pos_q;
	logic                              req_q;
	logic [psoe_pkg::SEED_W-1:0]       seed_q;

	// Architectural state outside the memory.
	logic signed [CW-1:0]       cur_q;
	logic                       shuf_q;
	logic                       act_q;
	logic [psoe_pkg::RNG_W-1:0] rng_q;
	logic                       fail_q;

	// Sequencer working registers.
	logic [IW-1:0] tgt_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] k_q;
	logic [IW-1:0] vi_q;
	logic [IW-1:0] j_q;
	logic          jv_q;
	logic [IW-1:0] p_q;
	logic [NW-1:0] s_q;
	logic          pend_q;
	logic          div_start_q;

	// Play-order memory with one read and one write port; read data is registered.
	logic [IW-1:0]          mem [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] vld_q;
	logic [IW-1:0]          rdata_q;
	logic [IW-1:0]          raddr_q;
	logic                   rvld_q;
	logic                   rd_en;
	logic [IW-1:0]          mem_ra;
	logic                   mem_we;
	logic [IW-1:0]          mem_wa;
	logic [IW-1:0]          mem_wd;
	logic                   clr_en;
	logic [QUEUE_DEPTH-1:0] clr_mask;
	logic [IW-1:0]          rd_val;

	// Result register.
	logic                              rsp_vld_q;
	logic                              rsp_load;
	logic [psoe_pkg::ITEM_W-1:0]       item_q;
	logic signed [psoe_pkg::CPOS_W-1:0] cpos_q;
	logic                              has_q;
	logic                              shuf_o_q;
	logic                              run_q;
	logic                              sfail_q;

	// Derived values.
	logic [NW-1:0]         n;
	logic                  has_trk;
	logic [IW-1:0]         cur_idx;
	logic signed [TW-1:0]  idx;
	logic signed [TW-1:0]  nsig;
	logic [IW-1:0]         tgt;
	logic [IW:0]           div_den;
	logic                  div_done;
	logic [IW-1:0]         div_rem;

	// ------------------------------------------------------------------
	// APB register.
	// ------------------------------------------------------------------
	assign cfg_idx = paddr[psoe_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign prdata  = (cfg_idx == psoe_pkg::REG_QLEN) ? psoe_pkg::APB_W'(qlen_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlen_q <= '0;
		end else if (cfg_wr && (cfg_idx == psoe_pkg::REG_QLEN)) begin
			qlen_q <= pwdata[psoe_pkg::QLEN_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Effective length, track test and jump target with wrap.
	// ------------------------------------------------------------------
	assign n = (32'(qlen_q) > 32'(QUEUE_DEPTH)) ? NW'(QUEUE_DEPTH) : NW'(qlen_q);

	assign has_trk = !cur_q[CW-1] && ((CW+1)'($unsigned(cur_q)) < (CW+1)'(n));
	assign cur_idx = cur_q[IW-1:0];

	always_comb begin
		priority if (mode_q == psoe_pkg::MODE_START) begin
			idx = TW'(pos_q);
		end else if (mode_q == psoe_pkg::MODE_PREV) begin
			idx = TW'(cur_q) - TW'(1);
		end else begin
			idx = TW'(cur_q) + TW'(1);
		end
		nsig = signed'(TW'(n));
		priority if (idx < 0) begin
			tgt = IW'(n - NW'(1));
		end else if (idx >= nsig) begin
			tgt = '0;
		end else begin
			tgt = IW'(idx);
		end
	end

	// ------------------------------------------------------------------
	// Memory port control, driven from the sequencer state.
	// ------------------------------------------------------------------
	always_comb begin
		rd_en  = 1'b0;
		mem_ra = '0;
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		unique case (state_q)
			S_GT_RD: begin
				rd_en  = 1'b1;
				mem_ra = tgt_q;
			end
			S_SH_RDJ, S_RDCUR, S_FX_RD: begin
				rd_en  = 1'b1;
				mem_ra = cur_idx;
			end
			S_SW_RDI: begin
				rd_en  = 1'b1;
				mem_ra = i_q;
			end
			S_SW_RDK: begin
				rd_en  = 1'b1;
				mem_ra = k_q;
			end
			S_SW_WRI: begin
				mem_we = 1'b1;
				mem_wa = i_q;
				mem_wd = rd_val;
			end
			S_SW_WRK: begin
				mem_we = 1'b1;
				mem_wa = k_q;
				mem_wd = vi_q;
			end
			S_SRCH: begin
				rd_en  = (s_q < n);
				mem_ra = s_q[IW-1:0];
			end
			S_FX_WRP: begin
				mem_we = 1'b1;
				mem_wa = p_q;
				mem_wd = rd_val;
			end
			S_FX_WRC: begin
				mem_we = 1'b1;
				mem_wa = cur_idx;
				mem_wd = j_q;
			end
			default: begin
			end
		endcase
	end

	// Identity order over the first n entries is restored by dropping their valid bits.
	assign clr_en = ((state_q == S_DISP) && (mode_q == psoe_pkg::MODE_RESTART)) ||
		(state_q == S_SH_START);

	always_comb begin
		for (int e = 0; e < QUEUE_DEPTH; e++) begin
			clr_mask[e] = (NW'(e) < n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clr_en) begin
			vld_q <= vld_q & ~clr_mask;
		end else if (mem_we) begin
			vld_q[mem_wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rdata_q <= mem[mem_ra];
			raddr_q <= mem_ra;
			rvld_q  <= vld_q[mem_ra];
		end
	end

	// An entry that was never written since identity was set holds its own address.
	assign rd_val = rvld_q ? rdata_q : raddr_q;

	// ------------------------------------------------------------------
	// Remainder unit for the swap partner k = rng mod (i + 1).
	// ------------------------------------------------------------------
	assign div_den = (IW+1)'(i_q) + (IW+1)'(1);

	psoe_rem #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start_q),
		.dividend(rng_q),
		.divisor (div_den),
		.done    (div_done),
		.rem     (div_rem)
	);

	// ------------------------------------------------------------------
	// Command sequencer.
	// ------------------------------------------------------------------
	assign rsp_load = (state_q == S_OUT) && (!rsp_vld_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q       <= '1;
			shuf_q      <= 1'b0;
			act_q       <= 1'b0;
			rng_q       <= psoe_pkg::RNG_RESET;
			fail_q      <= 1'b0;
			rsp_vld_q   <= 1'b0;
			div_start_q <= 1'b0;
			pend_q      <= 1'b0;
			mode_q      <= '0;
			pos_q       <= '0;
			req_q       <= 1'b0;
			seed_q      <= '0;
			tgt_q       <= '0;
			i_q         <= '0;
			k_q         <= '0;
			vi_q        <= '0;
			j_q         <= '0;
			jv_q        <= 1'b0;
			p_q         <= '0;
			s_q         <= '0;
		end else begin
			div_start_q <= 1'b0;
			if (rsp_vld_q && rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						mode_q  <= cmd.mode;
						pos_q   <= cmd.position;
						req_q   <= cmd.shuffle_request;
						seed_q  <= cmd.time_seed;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					fail_q  <= 1'b0;
					state_q <= S_RDCUR;
					unique case (mode_q)
						psoe_pkg::MODE_RESTART: begin
							rng_q  <= seed_q * psoe_pkg::SEED_MUL + psoe_pkg::RNG_W'(1);
							cur_q  <= '1;
							shuf_q <= 1'b0;
						end
						psoe_pkg::MODE_START: begin
							if (n == '0) begin
								fail_q <= 1'b1;
							end else begin
								tgt_q   <= tgt;
								state_q <= S_GT_RD;
							end
						end
						psoe_pkg::MODE_NEXT, psoe_pkg::MODE_PREV: begin
							if (n != '0) begin
								tgt_q   <= tgt;
								state_q <= S_GT_RD;
							end
						end
						psoe_pkg::MODE_SHUFFLE: begin
							if ((req_q == shuf_q) || (n <= NW'(1))) begin
								shuf_q <= req_q && (n > NW'(1));
							end else begin
								state_q <= S_SH_RDJ;
							end
						end
						psoe_pkg::MODE_ENDED: begin
							if (n <= NW'(1)) begin
								act_q <= 1'b0;
							end else begin
								tgt_q   <= tgt;
								state_q <= S_GT_RD;
							end
						end
						psoe_pkg::MODE_STOP: begin
							act_q <= 1'b0;
						end
						default: begin
						end
					endcase
				end
				S_GT_RD: begin
					state_q <= S_GT_CHK;
				end
				S_GT_CHK: begin
					// A stale entry from a longer queue blocks the jump.
					if (NW'(rd_val) < n) begin
						cur_q <= signed'(CW'(tgt_q));
						act_q <= 1'b1;
					end
					state_q <= S_RDCUR;
				end
				S_SH_RDJ: begin
					jv_q    <= has_trk;
					state_q <= S_SH_START;
				end
				S_SH_START: begin
					j_q <= rd_val;
					if (req_q) begin
						i_q     <= IW'(n - NW'(1));
						state_q <= S_SH_RNG;
					end else begin
						if (jv_q) begin
							cur_q <= signed'(CW'(rd_val));
						end
						shuf_q  <= 1'b0;
						state_q <= S_RDCUR;
					end
				end
				S_SH_RNG: begin
					rng_q       <= psoe_pkg::xorshift32(rng_q);
					div_start_q <= 1'b1;
					state_q     <= S_SH_DIV;
				end
				S_SH_DIV: begin
					if (div_done) begin
						k_q     <= div_rem;
						state_q <= S_SW_RDI;
					end
				end
				S_SW_RDI: begin
					state_q <= S_SW_RDK;
				end
				S_SW_RDK: begin
					vi_q    <= rd_val;
					state_q <= S_SW_WRI;
				end
				S_SW_WRI: begin
					state_q <= S_SW_WRK;
				end
				S_SW_WRK: begin
					if (i_q == IW'(1)) begin
						if (jv_q) begin
							s_q     <= '0;
							pend_q  <= 1'b0;
							state_q <= S_SRCH;
						end else begin
							shuf_q  <= 1'b1;
							state_q <= S_RDCUR;
						end
					end else begin
						i_q     <= i_q - IW'(1);
						state_q <= S_SH_RNG;
					end
				end
				S_SRCH: begin
					// Reads stream one entry a cycle; each answer is checked in the next cycle.
					if (pend_q && (rd_val == j_q)) begin
						p_q     <= raddr_q;
						state_q <= S_FX_RD;
					end else if (s_q < n) begin
						s_q    <= s_q + NW'(1);
						pend_q <= 1'b1;
					end else if (pend_q) begin
						pend_q <= 1'b0;
					end else begin
						shuf_q  <= 1'b1;
						state_q <= S_RDCUR;
					end
				end
				S_FX_RD: begin
					state_q <= S_FX_WRP;
				end
				S_FX_WRP: begin
					state_q <= S_FX_WRC;
				end
				S_FX_WRC: begin
					shuf_q  <= 1'b1;
					state_q <= S_RDCUR;
				end
				S_RDCUR: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (rsp_load) begin
						rsp_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			item_q   <= has_trk ? psoe_pkg::ITEM_W'(rd_val) : '0;
			cpos_q   <= psoe_pkg::CPOS_W'(cur_q);
			has_q    <= has_trk;
			shuf_o_q <= shuf_q;
			run_q    <= act_q;
			sfail_q  <= fail_q;
		end
	end

	assign cmd.ready         = (state_q == S_IDLE);
	assign rsp.valid         = rsp_vld_q;
	assign rsp.item_index    = item_q;
	assign rsp.current_pos   = cpos_q;
	assign rsp.has_track     = has_q;
	assign rsp.shuffle_state = shuf_o_q;
	assign rsp.queue_running = run_q;
	assign rsp.start_failed  = sfail_q;

`ifndef SYNTHESIS
	// The memory has no read-during-write forwarding, so the sequencer must never overlap them.
	a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && rd_en && (mem_wa == mem_ra)))
		else $error("play order read and written at the same entry in one cycle");

	// The swap partner drawn by the remainder unit lies at or below the swap position.
	a_swap_partner_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SW_RDI) |-> (k_q <= i_q))
		else $error("swap partner beyond the current shuffle position");

	// The remainder unit only finishes while the sequencer waits for it.
	a_rem_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_SH_DIV))
		else $error("remainder finished outside the wait state");
`endif

endmodule
